>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define TLG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define TLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tlg_pkg.sv
// Package: types, constants and datapath command/status for the life grid.
package tlg_pkg;

    localparam int REQ_W = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int NBR_W = 4;
    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_SIZE_RST = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [NBR_W-1:0] SURVIVE_CNT = 4'd2;
    localparam logic [NBR_W-1:0] BIRTH_CNT = 4'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_KILL   = 2'd0,
        REQ_REVIVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_STEP   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        RD_PREV  = 2'd0,
        RD_CUR   = 2'd1,
        RD_NEXT  = 2'd2,
        RD_AHEAD = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_ZERO = 2'd1,
        WR_MOD  = 2'd2,
        WR_LIFE = 2'd3
    } wr_op_t;

    typedef struct packed {
        logic    ld_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    ld_above;
        logic    ld_mid;
        logic    shift;
        logic    use_first;
        wr_op_t  wr_op;
        logic    cur_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_type_t req_type;
        logic      bad;
        logic      last_row;
        logic      clr_last;
        logic      out_free;
    } sts_t;

endpackage

>>> sv/tlg_if.sv
// Valid/ready channel interfaces for request and response beats.
interface tlg_in_if;
    logic                       valid;
    logic                       ready;
    logic [tlg_pkg::REQ_W-1:0]  req_type;
    logic [tlg_pkg::ROW_W-1:0]  row;
    logic [tlg_pkg::COL_W-1:0]  col;

    modport source (output valid, output req_type, output row, output col, input ready);
    modport sink (input valid, input req_type, input row, input col, output ready);
endinterface

interface tlg_out_if;
    logic                       valid;
    logic                       ready;
    logic                       cell_alive;
    logic [tlg_pkg::NBR_W-1:0]  live_neighbors;
    logic                       bad_index;

    modport source (output valid, output cell_alive, output live_neighbors,
                    output bad_index, input ready);
    modport sink (input valid, input cell_alive, input live_neighbors,
                  input bad_index, output ready);
endinterface

>>> sv/tlg_ctrl.sv
// Sequencer: clear pass, request decode, row fetch and generation sweep.
module tlg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tlg_pkg::sts_t sts,
    output tlg_pkg::cmd_t cmd
);
    import tlg_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH0,
        S_FETCH1,
        S_FETCH2,
        S_MODIFY,
        S_LIFE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_op = WR_ZERO;
                cmd.cur_inc = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.ld_req = 1'b1;
                    state_next = S_FETCH0;
                end
            end
            S_FETCH0:
            begin
                if (sts.req_type != REQ_STEP && sts.bad)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.req_type inside {REQ_KILL, REQ_REVIVE})
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_MODIFY;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_FETCH1;
                end
            end
            S_MODIFY:
            begin
                cmd.wr_op = WR_MOD;
                state_next = S_RESULT;
            end
            S_FETCH1:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_CUR;
                cmd.ld_above = 1'b1;
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_NEXT;
                cmd.ld_mid = 1'b1;
                state_next = (sts.req_type == REQ_STEP) ? S_LIFE : S_RESULT;
            end
            S_LIFE:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_AHEAD;
                cmd.wr_op = WR_LIFE;
                cmd.shift = 1'b1;
                cmd.use_first = sts.last_row;
                cmd.cur_inc = 1'b1;
                if (sts.last_row)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/tlg_datapath.sv
// Datapath: row memory, three-row window, neighbor counters and result register.
module tlg_datapath #(
    parameter int MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]     cfg_data,
    input  logic [tlg_pkg::REQ_W-1:0]     in_req_type,
    input  logic [tlg_pkg::ROW_W-1:0]     in_row,
    input  logic [tlg_pkg::COL_W-1:0]     in_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cell_alive,
    output logic [tlg_pkg::NBR_W-1:0]     live_neighbors,
    output logic                          bad_index,
    input  tlg_pkg::cmd_t                 cmd,
    output tlg_pkg::sts_t                 sts
);
    import tlg_pkg::*;

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int SZW0 = (NRW > NCW) ? NRW : NCW;
    localparam int SZW = ((SZW0 > CFG_W) ? SZW0 : CFG_W) + 1;
    localparam int NR_RST = (CFG_SIZE_RST > MAX_ROWS) ? MAX_ROWS : CFG_SIZE_RST;
    localparam int NC_RST = (CFG_SIZE_RST > MAX_COLS) ? MAX_COLS : CFG_SIZE_RST;

    function automatic logic [SZW-1:0] clamp_size(logic [SZW-1:0] v, logic [SZW-1:0] lim);
        return (v == '0) ? SZW'(1) : ((v > lim) ? lim : v);
    endfunction

    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];

    logic [NRW-1:0]      nr_reg, nr_next;
    logic [NCW-1:0]      nc_reg, nc_next;
    logic [RIW-1:0]      cur_reg, cur_next;
    logic                out_valid_reg, out_valid_next;
    req_type_t           req_type_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [MAX_COLS-1:0] above_reg, mid_reg, first_reg, rd_data_reg;
    logic                out_alive_reg, out_bad_reg;
    logic [NBR_W-1:0]    out_nbr_reg;

    logic [SZW-1:0]      cur_w, nr_w, nc_w, cfg_w;
    logic [RIW-1:0]      row_prev, row_next, row_ahead, rd_addr;
    logic                last_row, bad;
    logic [CIW-1:0]      nc_m1, col_idx;
    logic [MAX_COLS-1:0] below, life_row, col_bit, wr_data;
    logic [NBR_W-1:0]    nbr_cnt [MAX_COLS];
    logic                res_alive, res_bad;
    logic [NBR_W-1:0]    res_nbr;

    always_comb
    begin
        cur_w = SZW'(cur_reg);
        nr_w = SZW'(nr_reg);
        nc_w = SZW'(nc_reg);
        cfg_w = SZW'(cfg_data);
        last_row = (cur_w == nr_w - SZW'(1));
        row_prev = (cur_reg == '0) ? RIW'(nr_w - SZW'(1)) : RIW'(cur_w - SZW'(1));
        row_next = last_row ? '0 : RIW'(cur_w + SZW'(1));
        row_ahead = (cur_w + SZW'(2) < nr_w) ? RIW'(cur_w + SZW'(2)) : '0;
        case (cmd.rd_sel)
            RD_PREV:  rd_addr = row_prev;
            RD_CUR:   rd_addr = cur_reg;
            RD_NEXT:  rd_addr = row_next;
            RD_AHEAD: rd_addr = row_ahead;
            default:  rd_addr = cur_reg;
        endcase
        bad = (SZW'(row_reg) >= nr_w) || (SZW'(col_reg) >= nc_w);
        nc_m1 = CIW'(nc_w - SZW'(1));
        col_idx = CIW'(col_reg);
        below = cmd.use_first ? first_reg : rd_data_reg;
    end

    // Per-column neighbor count over the three-row window, columns wrap at nc.
    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_col
        localparam int JL = (j + MAX_COLS - 1) % MAX_COLS;
        localparam int JR = (j + 1) % MAX_COLS;
        logic [2:0] lft, rgt;
        logic       in_use;

        assign lft = (j == 0) ? {above_reg[nc_m1], mid_reg[nc_m1], below[nc_m1]}
                              : {above_reg[JL], mid_reg[JL], below[JL]};
        assign rgt = (nc_m1 == CIW'(j)) ? {above_reg[0], mid_reg[0], below[0]}
                                        : {above_reg[JR], mid_reg[JR], below[JR]};
        assign nbr_cnt[j] = NBR_W'(lft[2]) + NBR_W'(lft[1]) + NBR_W'(lft[0])
                          + NBR_W'(rgt[2]) + NBR_W'(rgt[1]) + NBR_W'(rgt[0])
                          + NBR_W'(above_reg[j]) + NBR_W'(below[j]);
        assign in_use = (SZW'(j) < nc_w);
        assign life_row[j] = !in_use ? mid_reg[j]
                           : (mid_reg[j] ? (nbr_cnt[j] == SURVIVE_CNT || nbr_cnt[j] == BIRTH_CNT)
                                         : (nbr_cnt[j] == BIRTH_CNT));
    end

    always_comb
    begin
        col_bit = MAX_COLS'(1) << col_idx;
        case (cmd.wr_op)
            WR_ZERO: wr_data = '0;
            WR_MOD:  wr_data = (req_type_reg == REQ_REVIVE) ? (rd_data_reg | col_bit)
                                                            : (rd_data_reg & ~col_bit);
            WR_LIFE: wr_data = life_row;
            default: wr_data = rd_data_reg;
        endcase
    end

    always_comb
    begin
        res_alive = 1'b0;
        res_nbr = '0;
        res_bad = 1'b0;
        if (req_type_reg != REQ_STEP)
        begin
            if (bad)
            begin
                res_bad = 1'b1;
            end
            else
            begin
                case (req_type_reg)
                    REQ_REVIVE:
                    begin
                        res_alive = 1'b1;
                    end
                    REQ_QUERY:
                    begin
                        res_alive = mid_reg[col_idx];
                        res_nbr = nbr_cnt[col_idx];
                    end
                    default:
                    begin
                        res_alive = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        nr_next = nr_reg;
        nc_next = nc_reg;
        if (cfg_we && cfg_index == CFG_ROWS)
        begin
            nr_next = NRW'(clamp_size(cfg_w, SZW'(MAX_ROWS)));
        end
        if (cfg_we && cfg_index == CFG_COLS)
        begin
            nc_next = NCW'(clamp_size(cfg_w, SZW'(MAX_COLS)));
        end
        cur_next = cur_reg;
        if (cmd.ld_req)
        begin
            cur_next = (req_type_t'(in_req_type) == REQ_STEP) ? '0 : RIW'(in_row);
        end
        else if (cmd.cur_inc)
        begin
            cur_next = RIW'(cur_w + SZW'(1));
        end
        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg <= NRW'(NR_RST);
            nc_reg <= NCW'(NC_RST);
            cur_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nr_reg <= nr_next;
            nc_reg <= nc_next;
            cur_reg <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            req_type_reg <= req_type_t'(in_req_type);
            row_reg <= in_row;
            col_reg <= in_col;
        end
        if (cmd.ld_above)
        begin
            above_reg <= rd_data_reg;
        end
        if (cmd.ld_mid)
        begin
            mid_reg <= rd_data_reg;
            first_reg <= rd_data_reg;
        end
        if (cmd.shift)
        begin
            above_reg <= mid_reg;
            mid_reg <= below;
        end
        if (cmd.out_load)
        begin
            out_alive_reg <= res_alive;
            out_nbr_reg <= res_nbr;
            out_bad_reg <= res_bad;
        end
    end

    // Row memory: one write at cur_reg, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_op != WR_NONE)
        begin
            grid_mem[cur_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    assign sts.req_type = req_type_reg;
    assign sts.bad = bad;
    assign sts.last_row = last_row;
    assign sts.clr_last = (cur_reg == RIW'(MAX_ROWS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign cell_alive = out_alive_reg;
    assign live_neighbors = out_nbr_reg;
    assign bad_index = out_bad_reg;

endmodule

>>> sv/toroidal_life_grid.sv
// Top level: toroidal life grid with request/response channels and size registers.
//
//   channel  dir  beat
//   req      in   req_type, row, col
//   rsp      out  cell_alive, live_neighbors, bad_index
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// After reset the row memory is cleared one row per cycle, all MAX_ROWS rows, req.ready low.
// Kill and revive read, modify and write back one row; query and step load a three-row
// window, and step then computes one grid row per cycle, bounded by the one read and one
// write port of the row memory. rsp is registered; while it stalls, the result waits
// in the sequencer and the next req beat is taken once the result register is loaded.
module toroidal_life_grid #(
    parameter int MAX_ROWS = tlg_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tlg_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tlg_in_if.sink                        req,
    tlg_out_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlg_pkg::CFG_W-1:0]     cfg_data
);
    import tlg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tlg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlg_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_req_type    (req.req_type),
        .in_row         (req.row),
        .in_col         (req.col),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .cell_alive     (rsp.cell_alive),
        .live_neighbors (rsp.live_neighbors),
        .bad_index      (rsp.bad_index),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

>>> sv/tlg_checker.sv
// Port-level checker for the life grid, bound to the top level.
`include "assert_macros.svh"

module tlg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      cell_alive,
    input logic [tlg_pkg::NBR_W-1:0] live_neighbors,
    input logic                      bad_index
);

    `TLG_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid, "rsp beat dropped while stalled")
    `TLG_ASSERT_NEXT(a_rsp_stable, out_valid && !out_ready, $stable(cell_alive) && $stable(live_neighbors) && $stable(bad_index), "rsp payload changed while stalled")
    `TLG_ASSERT(a_bad_clean, !(out_valid && bad_index) || (!cell_alive && live_neighbors == 4'd0), "bad index beat carries cell data")
    `TLG_ASSERT(a_nbr_range, !out_valid || live_neighbors <= 4'd8, "neighbor count above eight")

endmodule

bind toroidal_life_grid tlg_checker u_tlg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .cell_alive     (rsp.cell_alive),
    .live_neighbors (rsp.live_neighbors),
    .bad_index      (rsp.bad_index)
);
